// ----- rtl/iso2ep_pkg.sv -----
// shared types and constants for the timestamp to epoch converter
`default_nettype none

package iso2ep_pkg;

	// first character index at which a zone sign is recognized
	localparam int OFFSET_SEARCH_START = 11;
	localparam int CIDX_W = $clog2(OFFSET_SEARCH_START + 2);

	localparam int DATE_W  = 31;
	localparam int OFF_W   = 16;
	localparam int EPOCH_W = 41;

	// snapshot of the parsed text, handed from the scanner to the arithmetic
	typedef struct packed {
		logic [DATE_W-1:0] year;
		logic [DATE_W-1:0] month;
		logic [DATE_W-1:0] day;
		logic [DATE_W-1:0] hour;
		logic [DATE_W-1:0] minute;
		logic [DATE_W-1:0] second;
		logic [OFF_W-1:0]  off_hours;
		logic [OFF_W-1:0]  off_minutes;
		logic              off_negative;
		logic              complete;
	} fields_t;

endpackage

`default_nettype wire

// ----- rtl/iso2ep_if.sv -----
// valid/ready channel interfaces for character input and epoch output
`default_nettype none

interface iso2ep_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       is_last;

	modport source (output valid, output char_code, output is_last, input ready);
	modport sink (input valid, input char_code, input is_last, output ready);
endinterface

interface iso2ep_epoch_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [iso2ep_pkg::EPOCH_W-1:0]  epoch_seconds;
	logic                                   valid_res;

	modport source (output valid, output epoch_seconds, output valid_res, input ready);
	modport sink (input valid, input epoch_seconds, input valid_res, output ready);
endinterface

`default_nettype wire

// ----- rtl/iso8601_timestamp_to_epoch_core.sv -----
// top level: iso 8601 timestamp text to utc epoch seconds
//
//   channel  | dir | modport | words
//   ---------+-----+---------+-----------------------------------------------
//   text     | in  | sink    | char_code[7:0], is_last: one character a word
//   epoch    | out | source  | epoch_seconds[40:0] signed, valid_res: one per
//            |     |         | text, sent for the word carrying is_last
//
// one character word is taken every cycle while text.ready is high; the scanner updates its field
// accumulators in the cycle the word is accepted
// a result passes through a seven-stage arithmetic pipeline (two reciprocal
// multiplies, 365 and 86400 products, final sum); a new text may start in the
// cycle after is_last
// arst_n clears scanner state and all pipeline valid bits
// when the epoch side stalls, the pipeline fills and text.ready drops only
// once stage one holds a result that cannot move on
`default_nettype none

module iso8601_timestamp_to_epoch_core (
	input  logic           clk,
	input  logic           arst_n,
	iso2ep_char_if.sink    text,
	iso2ep_epoch_if.source epoch
);

	iso2ep_pkg::fields_t fields;
	logic                take;
	logic                push_ready;

	// a word is accepted on valid and ready; the last one also enters the pipeline
	assign take       = text.valid && push_ready;
	assign text.ready = push_ready;

	iso2ep_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.is_last   (text.is_last),
		.char_code (text.char_code),
		.fields    (fields)
	);

	// fields shown by the scanner already include the current character
	iso2ep_calc u_calc (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (text.valid && text.is_last),
		.push_ready (push_ready),
		.fields     (fields),
		.res        (epoch)
	);

endmodule

`default_nettype wire

// ----- rtl/iso2ep_scan.sv -----
// character scanner: date fields, separators and zone offset
`default_nettype none

module iso2ep_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic                is_last,
	input  logic [7:0]          char_code,
	output iso2ep_pkg::fields_t fields
);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_T     = 8'h54;

	localparam logic [2:0] FI_YEAR   = 3'd0;
	localparam logic [2:0] FI_MONTH  = 3'd1;
	localparam logic [2:0] FI_DAY    = 3'd2;
	localparam logic [2:0] FI_HOUR   = 3'd3;
	localparam logic [2:0] FI_SEC    = 3'd5;
	localparam logic [2:0] FI_DONE   = 3'd6;

	localparam logic [1:0] OP_SEARCH  = 2'd0;
	localparam logic [1:0] OP_HOURS   = 2'd1;
	localparam logic [1:0] OP_MINUTES = 2'd2;
	localparam logic [1:0] OP_DONE    = 2'd3;

	localparam int DW = iso2ep_pkg::DATE_W;
	localparam int OW = iso2ep_pkg::OFF_W;
	localparam logic [iso2ep_pkg::CIDX_W-1:0] CIDX_START =
		iso2ep_pkg::CIDX_W'(iso2ep_pkg::OFFSET_SEARCH_START);

	function automatic logic [DW-1:0] push_date(input logic [DW-1:0] acc, input logic [3:0] d);
		logic [DW+3:0] v;
		v = ((DW+4)'(acc) << 3) + ((DW+4)'(acc) << 1) + (DW+4)'(d);
		return (v > (DW+4)'({DW{1'b1}})) ? {DW{1'b1}} : v[DW-1:0];
	endfunction

	function automatic logic [OW-1:0] push_off(input logic [OW-1:0] acc, input logic [3:0] d);
		logic [OW+3:0] v;
		v = ((OW+4)'(acc) << 3) + ((OW+4)'(acc) << 1) + (OW+4)'(d);
		return (v > (OW+4)'({OW{1'b1}})) ? {OW{1'b1}} : v[OW-1:0];
	endfunction

	function automatic logic [7:0] sep_of(input logic [2:0] idx);
		case (idx)
			FI_YEAR, FI_MONTH: return CH_DASH;
			FI_DAY:            return CH_T;
			default:           return CH_COLON;
		endcase
	endfunction

	logic [iso2ep_pkg::CIDX_W-1:0] cidx_q, cidx_d;
	logic [2:0]    fidx_q, fidx_d;
	logic [DW-1:0] acc_q, acc_d;
	logic          seen_q, seen_d;
	logic [DW-1:0] year_q, year_d, month_q, month_d, day_q, day_d;
	logic [DW-1:0] hour_q, hour_d, minute_q, minute_d;
	logic          mism_q, mism_d;
	logic [1:0]    ophase_q, ophase_d;
	logic          oneg_q, oneg_d;
	logic [OW-1:0] offh_q, offh_d, offm_q, offm_d;
	logic          hseen_q, hseen_d;
	logic          ended_q, ended_d;
	logic          is_digit;
	logic [3:0]    digit;

	always_comb begin
		cidx_d   = cidx_q;
		fidx_d   = fidx_q;
		acc_d    = acc_q;
		seen_d   = seen_q;
		year_d   = year_q;
		month_d  = month_q;
		day_d    = day_q;
		hour_d   = hour_q;
		minute_d = minute_q;
		mism_d   = mism_q;
		ophase_d = ophase_q;
		oneg_d   = oneg_q;
		offh_d   = offh_q;
		offm_d   = offm_q;
		hseen_d  = hseen_q;
		ended_d  = ended_q;
		is_digit = char_code inside {[8'h30:8'h39]};
		digit    = char_code[3:0];
		if (!ended_q) begin
			if (char_code == CH_NUL) begin
				ended_d = 1'b1;
			end else begin
				// date fields
				if (!mism_q && fidx_q != FI_DONE) begin
					if (is_digit) begin
						acc_d  = push_date(acc_q, digit);
						seen_d = 1'b1;
					end else if (!seen_q) begin
						mism_d = 1'b1;
					end else if (fidx_q == FI_SEC) begin
						fidx_d = FI_DONE;
					end else if (char_code == sep_of(fidx_q)) begin
						case (fidx_q)
							FI_YEAR:  year_d  = acc_q;
							FI_MONTH: month_d = acc_q;
							FI_DAY:   day_d   = acc_q;
							FI_HOUR:  hour_d  = acc_q;
							default:  minute_d = acc_q;
						endcase
						fidx_d = fidx_q + 3'd1;
						acc_d  = '0;
						seen_d = 1'b0;
					end else begin
						mism_d = 1'b1;
					end
				end
				// zone offset
				case (ophase_q)
					OP_SEARCH: begin
						if (cidx_q == CIDX_START &&
							(char_code == CH_PLUS || char_code == CH_DASH)) begin
							ophase_d = OP_HOURS;
							oneg_d   = (char_code == CH_DASH);
						end
					end
					OP_HOURS: begin
						if (is_digit) begin
							offh_d  = push_off(offh_q, digit);
							hseen_d = 1'b1;
						end else if (char_code == CH_COLON && hseen_q) begin
							ophase_d = OP_MINUTES;
						end else begin
							ophase_d = OP_DONE;
						end
					end
					OP_MINUTES: begin
						if (is_digit) begin
							offm_d = push_off(offm_q, digit);
						end else begin
							ophase_d = OP_DONE;
						end
					end
					default: begin
					end
				endcase
				if (cidx_q != CIDX_START) begin
					cidx_d = cidx_q + 1'b1;
				end
			end
		end
	end

	always_comb begin
		fields.year         = year_d;
		fields.month        = month_d;
		fields.day          = day_d;
		fields.hour         = hour_d;
		fields.minute       = minute_d;
		fields.second       = acc_d;
		fields.off_hours    = offh_d;
		fields.off_minutes  = offm_d;
		fields.off_negative = oneg_d;
		fields.complete     = !mism_d && (fidx_d == FI_DONE || (fidx_d == FI_SEC && seen_d));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cidx_q   <= '0;
			fidx_q   <= FI_YEAR;
			acc_q    <= '0;
			seen_q   <= 1'b0;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			mism_q   <= 1'b0;
			ophase_q <= OP_SEARCH;
			oneg_q   <= 1'b0;
			offh_q   <= '0;
			offm_q   <= '0;
			hseen_q  <= 1'b0;
			ended_q  <= 1'b0;
		end else if (take) begin
			if (is_last) begin
				cidx_q   <= '0;
				fidx_q   <= FI_YEAR;
				acc_q    <= '0;
				seen_q   <= 1'b0;
				year_q   <= '0;
				month_q  <= '0;
				day_q    <= '0;
				hour_q   <= '0;
				minute_q <= '0;
				mism_q   <= 1'b0;
				ophase_q <= OP_SEARCH;
				oneg_q   <= 1'b0;
				offh_q   <= '0;
				offm_q   <= '0;
				hseen_q  <= 1'b0;
				ended_q  <= 1'b0;
			end else begin
				cidx_q   <= cidx_d;
				fidx_q   <= fidx_d;
				acc_q    <= acc_d;
				seen_q   <= seen_d;
				year_q   <= year_d;
				month_q  <= month_d;
				day_q    <= day_d;
				hour_q   <= hour_d;
				minute_q <= minute_d;
				mism_q   <= mism_d;
				ophase_q <= ophase_d;
				oneg_q   <= oneg_d;
				offh_q   <= offh_d;
				offm_q   <= offm_d;
				hseen_q  <= hseen_d;
				ended_q  <= ended_d;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/iso2ep_calc.sv -----
// seven-stage pipeline from parsed fields to utc epoch seconds
`default_nettype none

module iso2ep_calc (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  iso2ep_pkg::fields_t   fields,
	iso2ep_epoch_if.source        res
);

	localparam int DW = iso2ep_pkg::DATE_W;
	// floor(x / 12) = (x * M12) >> 35 for x below 2^33
	localparam logic [31:0] M12 = 32'hAAAAAAAB;
	// floor(x / 25) = (x * M25) >> 35 for x below 2^32
	localparam logic [30:0] M25 = 31'd1374389535;
	// 146000 + 100 - 4 + 1 + 719468 + 1, folded offsets of the day count
	localparam logic signed [33:0] DAY_BIAS = 34'sd865566;

	function automatic logic [8:0] doy_of(input logic [3:0] mrem);
		case (mrem)
			4'd0:    return 9'd306;
			4'd1:    return 9'd337;
			4'd2:    return 9'd0;
			4'd3:    return 9'd31;
			4'd4:    return 9'd61;
			4'd5:    return 9'd92;
			4'd6:    return 9'd122;
			4'd7:    return 9'd153;
			4'd8:    return 9'd184;
			4'd9:    return 9'd214;
			4'd10:   return 9'd245;
			default: return 9'd275;
		endcase
	endfunction

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic r1, r2, r3, r4, r5, r6, r7;

	assign r7 = !vld_s7 || res.ready;
	assign r6 = !vld_s6 || r7;
	assign r5 = !vld_s5 || r6;
	assign r4 = !vld_s4 || r5;
	assign r3 = !vld_s3 || r4;
	assign r2 = !vld_s2 || r3;
	assign r1 = !vld_s1 || r2;
	assign push_ready = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7} <= '0;
		end else begin
			if (r1) vld_s1 <= push_valid;
			if (r2) vld_s2 <= vld_s1;
			if (r3) vld_s3 <= vld_s2;
			if (r4) vld_s4 <= vld_s3;
			if (r5) vld_s5 <= vld_s4;
			if (r6) vld_s6 <= vld_s5;
			if (r7) vld_s7 <= vld_s6;
		end
	end

	// stage 1: field snapshot
	iso2ep_pkg::fields_t f_s1;
	always_ff @(posedge clk) begin
		if (r1 && push_valid) f_s1 <= fields;
	end

	// stage 2: month carry product, time-of-day and zone offset products
	logic [DW-1:0] m0;
	logic [62:0]   prod12;
	logic [27:0]   q12_s2;
	logic [DW-1:0] m0_s2, year_s2, day_s2, sec_s2;
	logic          mz_s2, neg_s2, ok_s2;
	logic [42:0]   h3600_s2;
	logic [36:0]   m60_s2;
	logic [28:0]   off_s2;

	always_comb begin
		m0     = f_s1.month - 1'b1;
		prod12 = 63'(m0) * 63'(M12);
	end

	always_ff @(posedge clk) begin
		if (r2 && vld_s1) begin
			q12_s2   <= prod12[62:35];
			m0_s2    <= m0;
			mz_s2    <= (f_s1.month == '0);
			year_s2  <= f_s1.year;
			day_s2   <= f_s1.day;
			sec_s2   <= f_s1.second;
			neg_s2   <= f_s1.off_negative;
			ok_s2    <= f_s1.complete;
			h3600_s2 <= 43'(f_s1.hour) * 43'd3600;
			m60_s2   <= 37'(f_s1.minute) * 37'd60;
			off_s2   <= 29'(f_s1.off_hours) * 29'd3600 + 29'(f_s1.off_minutes) * 29'd60;
		end
	end

	// stage 3: march-based year, day-of-year bias, seconds part
	logic signed [28:0] carry;
	logic [30:0]        mrem_full;
	logic [3:0]         mrem;
	logic signed [32:0] zsum;
	logic [31:0]        z_s3;
	logic signed [33:0] base_s3;
	logic signed [44:0] part_s3;
	logic               ok_s3;

	always_comb begin
		mrem_full = m0_s2 - 31'(q12_s2) * 31'd12;
		carry     = mz_s2 ? -29'sd1 : $signed({1'b0, q12_s2});
		mrem      = mz_s2 ? 4'd11 : mrem_full[3:0];
		zsum      = $signed({2'b00, year_s2}) + 33'(carry) + 33'sd400
			- ((mrem <= 4'd1) ? 33'sd1 : 33'sd0);
	end

	always_ff @(posedge clk) begin
		if (r3 && vld_s2) begin
			z_s3    <= zsum[31:0];
			base_s3 <= $signed({3'b000, day_s2}) + $signed({25'd0, doy_of(mrem)}) - DAY_BIAS;
			part_s3 <= $signed({2'b00, h3600_s2}) + $signed({8'd0, m60_s2})
				+ $signed({14'd0, sec_s2})
				+ (neg_s2 ? $signed({16'd0, off_s2}) : -$signed({16'd0, off_s2}));
			ok_s3   <= ok_s2;
		end
	end

	// stage 4: leap corrections and the 365-day product
	logic [60:0]        prod25;
	logic [29:0]        w_s4;
	logic [25:0]        q25_s4;
	logic [40:0]        zz_s4;
	logic signed [33:0] base_s4;
	logic signed [44:0] part_s4;
	logic               ok_s4;

	assign prod25 = 61'(z_s3[31:2]) * 61'(M25);

	always_ff @(posedge clk) begin
		if (r4 && vld_s3) begin
			w_s4    <= z_s3[31:2];
			q25_s4  <= prod25[60:35];
			zz_s4   <= 41'(z_s3) * 41'd365;
			base_s4 <= base_s3;
			part_s4 <= part_s3;
			ok_s4   <= ok_s3;
		end
	end

	// stage 5: day count since the epoch
	logic signed [41:0] days_s5;
	logic signed [44:0] part_s5;
	logic               ok_s5;

	always_ff @(posedge clk) begin
		if (r5 && vld_s4) begin
			days_s5 <= $signed({1'b0, zz_s4}) + $signed({12'd0, w_s4})
				- $signed({16'd0, q25_s4}) + $signed({18'd0, q25_s4[25:2]})
				+ 42'(base_s4);
			part_s5 <= part_s4;
			ok_s5   <= ok_s4;
		end
	end

	// stage 6: days to seconds
	logic signed [59:0] dsec_s6;
	logic signed [44:0] part_s6;
	logic               ok_s6;

	always_ff @(posedge clk) begin
		if (r6 && vld_s5) begin
			dsec_s6 <= 60'(days_s5) * 60'sd86400;
			part_s6 <= part_s5;
			ok_s6   <= ok_s5;
		end
	end

	// stage 7: final sum, 41-bit range check, result register
	logic signed [60:0] t;
	logic               in_range;
	logic [iso2ep_pkg::EPOCH_W-1:0] epoch_s7;
	logic               ok_s7;

	always_comb begin
		t        = 61'(dsec_s6) + 61'(part_s6);
		in_range = (&t[60:40]) || !(|t[60:40]);
	end

	always_ff @(posedge clk) begin
		if (r7 && vld_s6) begin
			ok_s7    <= ok_s6 && in_range;
			epoch_s7 <= (ok_s6 && in_range) ? t[40:0] : '0;
		end
	end

	assign res.valid         = vld_s7;
	assign res.epoch_seconds = $signed(epoch_s7);
	assign res.valid_res     = ok_s7;

endmodule

`default_nettype wire

// ----- rtl/iso2ep_check.sv -----
// port-level checks for the timestamp converter and their bind
`default_nettype none

module iso2ep_check (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [iso2ep_pkg::EPOCH_W-1:0] epoch_seconds,
	input logic                                  valid_res
);

	// a rejected text always reports zero seconds
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> epoch_seconds == '0)
		else $error("rejected text with nonzero epoch");

	// back pressure on the input only ever comes from a stalled result
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with no result pending");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(epoch_seconds) && $stable(valid_res))
		else $error("result changed while stalled");

endmodule

bind iso8601_timestamp_to_epoch_core iso2ep_check u_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (text.valid),
	.in_ready      (text.ready),
	.out_valid     (epoch.valid),
	.out_ready     (epoch.ready),
	.epoch_seconds (epoch.epoch_seconds),
	.valid_res     (epoch.valid_res)
);

`default_nettype wire
